// ===== hw/rtl/rpst_pkg.sv =====
// Package for the radio PHY state tracker: payload structs, operation and
// state codes, and the span slot type. No dependencies.
`default_nettype none

package rpst_pkg;

  localparam int TW = 48;

  localparam logic [3:0] OP_QUERY  = 4'd0;
  localparam logic [3:0] OP_TX     = 4'd1;
  localparam logic [3:0] OP_RX     = 4'd2;
  localparam logic [3:0] OP_SWITCH = 4'd3;
  localparam logic [3:0] OP_RX_END = 4'd4;
  localparam logic [3:0] OP_BUSY   = 4'd5;
  localparam logic [3:0] OP_SLEEP  = 4'd6;
  localparam logic [3:0] OP_WAKE   = 4'd7;
  localparam logic [3:0] OP_OFF    = 4'd8;
  localparam logic [3:0] OP_ON     = 4'd9;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BUSY   = 3'd1;
  localparam logic [2:0] ST_TX     = 3'd2;
  localparam logic [2:0] ST_RX     = 3'd3;
  localparam logic [2:0] ST_SWITCH = 3'd4;
  localparam logic [2:0] ST_SLEEP  = 3'd5;
  localparam logic [2:0] ST_OFF    = 3'd6;

  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [3:0]    operation;
    logic [TW-1:0] now;
    logic [TW-1:0] duration;
    logic [3:0]    entry_index;
    logic [7:0]    band_id;
    logic          is_primary;
  } req_t;

  typedef struct packed {
    logic                 kind;
    logic [2:0]           span_state;
    logic [TW-1:0]        span_start;
    logic [TW-1:0]        span_length;
    logic [2:0]           current_state;
    logic [TW-1:0]        delay_until_idle;
    logic signed [TW-1:0] delay_since_idle;
    logic                 fault;
    logic                 last;
  } rsp_t;

  // Span waiting to go out; its length is tsub0(len_a, len_b).
  typedef struct packed {
    logic [2:0]    st;
    logic [TW-1:0] start;
    logic [TW-1:0] len_a;
    logic [TW-1:0] len_b;
  } span_t;

  function automatic logic [TW-1:0] tmax(input logic [TW-1:0] a, input logic [TW-1:0] b);
    tmax = (a > b) ? a : b;
  endfunction

  function automatic logic [TW-1:0] tsub0(input logic [TW-1:0] a, input logic [TW-1:0] b);
    tsub0 = (a > b) ? (a - b) : '0;
  endfunction

  function automatic span_t mk_span(input logic [2:0] st, input logic [TW-1:0] start,
                                    input logic [TW-1:0] a, input logic [TW-1:0] b);
    mk_span.st    = st;
    mk_span.start = start;
    mk_span.len_a = a;
    mk_span.len_b = b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpst_ram.sv =====
// Generic single write port RAM with one registered read port.
// Used for the busy table columns. No dependencies.
`default_nettype none

module rpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/radio_phy_state_tracker_core.sv =====
// Radio PHY state tracker: resolves PHY state from timestamped events and
// emits closed state spans plus one status transaction per event.
// Depends on rpst_pkg and rpst_ram.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_t (event)
//   rsp     | out       | rsp_valid/stall   | rsp_t (span or status)
//
// One event at a time. Query, rx end, sleep, wake, off and on read the entry,
// plan, emit their spans and then a status; busy adds a re-read after its write.
// Tx, rx and switch add a sweep over the busy table, one entry per cycle
// through the single read and write port of each table RAM.
// Reset clears the flags, times and known bits at once; no clearing pass.
// A stalled rsp holds the sequencer until the register frees.
`default_nettype none

module radio_phy_state_tracker_core
  import rpst_pkg::*;
#(
  parameter int BUSY_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int IW = (BUSY_ENTRIES > 1) ? $clog2(BUSY_ENTRIES) : 1;
  localparam int CW = $clog2(BUSY_ENTRIES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV1   = 4'd2;
  localparam logic [3:0] S_EV2   = 4'd3;
  localparam logic [3:0] S_EXT   = 4'd4;
  localparam logic [3:0] S_PLAN  = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_SWEEP = 4'd7;
  localparam logic [3:0] S_STAT  = 4'd8;

  localparam logic [1:0] PASS_PRE    = 2'd0;
  localparam logic [1:0] PASS_POST   = 2'd1;
  localparam logic [1:0] PASS_STATUS = 2'd2;

  logic [3:0]    state;
  logic [1:0]    pass;

  logic [3:0]    op;
  logic [TW-1:0] now_r, dur_r, endv;
  logic [3:0]    idx_r;
  logic [7:0]    band_r;
  logic          prim_r;

  logic [TW-1:0] tx_end, tx_begin, rx_end, rx_begin, switch_end, sleep_begin;
  logic          asleep, powered_off;
  logic [BUSY_ENTRIES-1:0] end_known, begin_known;

  logic [TW-1:0] m3, end_r, beg_r, bs, is_v;
  logic          ecbig;
  logic [2:0]    st;
  logic          fault_r;

  span_t         slot [0:3];
  logic [1:0]    nslot, k;
  logic          do_sweep, do_clamp;
  logic [CW-1:0] cnt;

  // RAM ports
  logic [IW-1:0] rd_addr, wa, idx_a;
  logic [TW-1:0] rd_end, rd_begin, wd_end, wd_beg;
  logic [7:0]    rd_band, wd_band;
  logic          we_end, we_beg, we_band;

  logic          idx_ok, free;
  logic [TW:0]   sum;

  assign idx_a  = IW'(idx_r);
  assign idx_ok = 32'(idx_r) < 32'(BUSY_ENTRIES);
  assign free   = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign sum    = {1'b0, req.now} + {1'b0, req.duration};

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = IW'(req.entry_index);
    end else if (state == S_SWEEP && cnt != CW'(BUSY_ENTRIES)) begin
      rd_addr = cnt[IW-1:0];
    end else begin
      rd_addr = idx_a;
    end
  end

  rpst_ram #(.WIDTH(TW), .DEPTH(BUSY_ENTRIES)) u_end (
    .clk(clk), .we(we_end), .waddr(wa), .wdata(wd_end), .raddr(rd_addr), .rdata(rd_end)
  );
  rpst_ram #(.WIDTH(TW), .DEPTH(BUSY_ENTRIES)) u_begin (
    .clk(clk), .we(we_beg), .waddr(wa), .wdata(wd_beg), .raddr(rd_addr), .rdata(rd_begin)
  );
  rpst_ram #(.WIDTH(8), .DEPTH(BUSY_ENTRIES)) u_band (
    .clk(clk), .we(we_band), .waddr(wa), .wdata(wd_band), .raddr(rd_addr), .rdata(rd_band)
  );

  // ---------------- planning of one event ----------------
  span_t         p_slot [0:3];
  span_t         tail;
  logic [1:0]    p_n;
  logic          p_fault, p_sweep, p_clamp, p_ext, p_begin, has_tail;
  logic          cl_rx, cl_tx, cl_busy, cl_idle;
  logic [TW-1:0] tx_end_n, tx_begin_n, rx_end_n, rx_begin_n, switch_end_n, sleep_begin_n;
  logic          asleep_n, off_n;
  logic [TW-1:0] new_end;

  assign new_end = tmax(end_r, endv);

  always_comb begin
    p_n = 2'd0;
    p_fault = 1'b0; p_sweep = 1'b0; p_clamp = 1'b0; p_ext = 1'b0; p_begin = 1'b0;
    cl_rx = 1'b0; cl_tx = 1'b0; cl_busy = 1'b0; cl_idle = 1'b0;
    has_tail = 1'b0;
    tail = mk_span(ST_IDLE, '0, '0, '0);
    for (int i = 0; i < 4; i++) begin
      p_slot[i] = mk_span(ST_IDLE, '0, '0, '0);
    end
    tx_end_n = tx_end; tx_begin_n = tx_begin; rx_end_n = rx_end; rx_begin_n = rx_begin;
    switch_end_n = switch_end; sleep_begin_n = sleep_begin;
    asleep_n = asleep; off_n = powered_off;

    case (op)
      OP_QUERY: begin
      end
      OP_TX, OP_SWITCH: begin
        if (st == ST_RX) begin
          cl_rx = 1'b1;
          rx_end_n = now_r;
        end else if (st == ST_BUSY) begin
          cl_busy = 1'b1;
        end else if (st == ST_IDLE) begin
          cl_idle = 1'b1;
        end else begin
          p_fault = 1'b1;
        end
        if (!p_fault) begin
          has_tail = 1'b1;
          if (op == OP_TX) begin
            tail = mk_span(ST_TX, now_r, dur_r, '0);
            tx_end_n = endv;
            tx_begin_n = now_r;
            p_sweep = 1'b1;
          end else begin
            tail = mk_span(ST_SWITCH, now_r, dur_r, '0);
            switch_end_n = endv;
            p_clamp = 1'b1;
          end
        end
      end
      OP_RX, OP_SLEEP: begin
        if (st == ST_IDLE) begin
          cl_idle = 1'b1;
        end else if (st == ST_BUSY) begin
          cl_busy = 1'b1;
        end else begin
          p_fault = 1'b1;
        end
        if (!p_fault) begin
          if (op == OP_RX) begin
            rx_begin_n = now_r;
            rx_end_n = endv;
            p_sweep = 1'b1;
          end else begin
            asleep_n = 1'b1;
            sleep_begin_n = now_r;
          end
        end
      end
      OP_RX_END: begin
        cl_rx = 1'b1;
        rx_end_n = now_r;
      end
      OP_BUSY: begin
        if (st != ST_RX) begin
          cl_idle = (st == ST_IDLE) && prim_r;
          p_begin = (st != ST_BUSY);
          if (prim_r) begin
            has_tail = 1'b1;
            tail = mk_span(ST_BUSY, now_r, dur_r, '0);
          end
        end
      end
      OP_WAKE: begin
        if (st != ST_SLEEP) begin
          p_fault = 1'b1;
        end else begin
          asleep_n = 1'b0;
          p_ext = 1'b1;
          if (prim_r) begin
            has_tail = 1'b1;
            tail = mk_span(ST_SLEEP, sleep_begin, now_r, sleep_begin);
          end
        end
      end
      OP_OFF: begin
        if (st == ST_RX) begin
          cl_rx = 1'b1;
          rx_end_n = now_r;
        end else if (st == ST_TX) begin
          cl_tx = 1'b1;
          tx_end_n = now_r;
        end else if (st == ST_IDLE) begin
          cl_idle = 1'b1;
        end else if (st == ST_BUSY) begin
          cl_busy = 1'b1;
        end else begin
          p_fault = 1'b1;
        end
        if (!p_fault) begin
          off_n = 1'b1;
        end
      end
      OP_ON: begin
        if (st != ST_OFF) begin
          p_fault = 1'b1;
        end else begin
          off_n = 1'b0;
          p_ext = 1'b1;
        end
      end
      default: begin
        p_fault = 1'b1;
      end
    endcase

    // closing spans first, then the span the event opens
    if (cl_rx) begin
      p_slot[p_n] = mk_span(ST_RX, rx_begin, now_r, rx_begin);
      p_n = p_n + 2'd1;
    end
    if (cl_tx) begin
      p_slot[p_n] = mk_span(ST_TX, tx_begin, now_r, tx_begin);
      p_n = p_n + 2'd1;
    end
    if (cl_busy) begin
      p_slot[p_n] = mk_span(ST_BUSY, bs, now_r, bs);
      p_n = p_n + 2'd1;
    end
    if (cl_idle) begin
      if (ecbig) begin
        p_slot[p_n] = mk_span(ST_BUSY, bs, is_v, bs);
        p_n = p_n + 2'd1;
      end
      p_slot[p_n] = mk_span(ST_IDLE, is_v, now_r, is_v);
      p_n = p_n + 2'd1;
    end
    if (has_tail) begin
      p_slot[p_n] = tail;
      p_n = p_n + 2'd1;
    end
  end

  // ---------------- table writes ----------------
  logic [CW-1:0] jw;
  logic [IW-1:0] ja;
  logic          ek_j, bk_j;

  assign jw   = cnt - CW'(1);
  assign ja   = jw[IW-1:0];
  assign ek_j = end_known[ja];
  assign bk_j = begin_known[ja];

  always_comb begin
    we_end = 1'b0; we_beg = 1'b0; we_band = 1'b0;
    wa = idx_a;
    wd_end = new_end; wd_beg = now_r; wd_band = band_r;
    case (state)
      S_EXT: begin
        we_end  = idx_ok;
        we_band = idx_ok;
      end
      S_PLAN: begin
        we_end  = p_ext && idx_ok;
        we_beg  = p_begin && idx_ok;
        we_band = (p_ext || p_begin) && idx_ok;
      end
      S_SWEEP: begin
        wa = ja;
        wd_end = rd_end;
        wd_beg = rd_begin;
        if (cnt != '0) begin
          we_end = 1'b1;
          we_beg = do_sweep;
          if (do_sweep) begin
            if (bk_j && rd_band != band_r && now_r < rd_begin) begin
              wd_beg = now_r;
            end
            if (ek_j && rd_band != band_r) begin
              wd_end = tmax(rd_end, endv);
            end
          end else if (ek_j && now_r < rd_end) begin
            wd_end = now_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- status arithmetic ----------------
  logic [TW-1:0] du_sel, du;
  logic [TW:0]   sdiff;
  logic [TW-1:0] mag;

  always_comb begin
    case (st)
      ST_RX:     du_sel = rx_end;
      ST_TX:     du_sel = tx_end;
      ST_SWITCH: du_sel = switch_end;
      ST_BUSY:   du_sel = end_r;
      default:   du_sel = now_r;
    endcase
    du = tsub0(du_sel, now_r);
    sdiff = {1'b0, now_r} - {1'b0, is_v};
    if (!sdiff[TW]) begin
      // saturate at the positive limit
      mag = sdiff[TW-1] ? {1'b0, {(TW-1){1'b1}}} : sdiff[TW-1:0];
    end else begin
      mag = (sdiff[TW:TW-1] == 2'b11) ? sdiff[TW-1:0] : {1'b1, {(TW-1){1'b0}}};
    end
  end

  // ---------------- output transaction ----------------
  rsp_t          rsp_next;
  logic          rsp_load;

  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '0;
    if (state == S_EMIT && k != nslot) begin
      rsp_load = free;
      rsp_next.kind = KIND_SPAN;
      rsp_next.span_state = slot[k].st;
      rsp_next.span_start = slot[k].start;
      rsp_next.span_length = tsub0(slot[k].len_a, slot[k].len_b);
    end else if (state == S_STAT) begin
      rsp_load = free;
      rsp_next.kind = KIND_STATUS;
      rsp_next.current_state = st;
      rsp_next.delay_until_idle = du;
      rsp_next.delay_since_idle = mag;
      rsp_next.fault = fault_r;
      rsp_next.last = 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass <= PASS_PRE;
      rsp_valid <= 1'b0;
      tx_end <= '0; tx_begin <= '0; rx_end <= '0; rx_begin <= '0;
      switch_end <= '0; sleep_begin <= '0;
      asleep <= 1'b0; powered_off <= 1'b0;
      end_known <= '0; begin_known <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp <= rsp_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op <= req.operation;
            now_r <= req.now;
            dur_r <= req.duration;
            idx_r <= req.entry_index;
            band_r <= req.band_id;
            prim_r <= req.is_primary;
            endv <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            pass <= PASS_PRE;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EV1;
        end
        S_EV1: begin
          end_r <= (idx_ok && end_known[idx_a]) ? rd_end : '0;
          beg_r <= (idx_ok && begin_known[idx_a]) ? rd_begin : '0;
          m3 <= tmax(tmax(rx_end, tx_end), switch_end);
          state <= S_EV2;
        end
        S_EV2: begin
          bs <= tmax(m3, beg_r);
          is_v <= tmax(m3, end_r);
          ecbig <= end_r > m3;
          if (powered_off) begin
            st <= ST_OFF;
          end else if (asleep) begin
            st <= ST_SLEEP;
          end else if (tx_end > now_r) begin
            st <= ST_TX;
          end else if (rx_end > now_r) begin
            st <= ST_RX;
          end else if (switch_end > now_r) begin
            st <= ST_SWITCH;
          end else if (end_r > now_r) begin
            st <= ST_BUSY;
          end else begin
            st <= ST_IDLE;
          end
          if (pass == PASS_STATUS) begin
            state <= S_STAT;
          end else if (op == OP_BUSY && pass == PASS_PRE) begin
            state <= S_EXT;
          end else begin
            state <= S_PLAN;
          end
        end
        S_EXT: begin
          if (idx_ok) begin
            end_known[idx_a] <= 1'b1;
          end
          pass <= PASS_POST;
          state <= S_RD;
        end
        S_PLAN: begin
          for (int i = 0; i < 4; i++) begin
            slot[i] <= p_slot[i];
          end
          nslot <= p_n;
          k <= 2'd0;
          fault_r <= p_fault;
          do_sweep <= p_sweep;
          do_clamp <= p_clamp;
          tx_end <= tx_end_n; tx_begin <= tx_begin_n;
          rx_end <= rx_end_n; rx_begin <= rx_begin_n;
          switch_end <= switch_end_n; sleep_begin <= sleep_begin_n;
          asleep <= asleep_n; powered_off <= off_n;
          if (p_ext && idx_ok) begin
            end_known[idx_a] <= 1'b1;
          end
          if (p_begin && idx_ok) begin
            begin_known[idx_a] <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (k != nslot) begin
            if (free) begin
              k <= k + 2'd1;
            end
          end else if (do_sweep || do_clamp) begin
            cnt <= '0;
            state <= S_SWEEP;
          end else begin
            pass <= PASS_STATUS;
            state <= S_RD;
          end
        end
        S_SWEEP: begin
          if (cnt == CW'(BUSY_ENTRIES)) begin
            pass <= PASS_STATUS;
            state <= S_RD;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_STAT: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/radio_phy_state_tracker_core_tb.sv =====
// Testbench for radio_phy_state_tracker_core: drives PHY events through a directed
// table and random event sequences, and checks every span and status transaction.
// Depends on rpst_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

module radio_phy_state_tracker_core_tb;
  import rpst_pkg::*;

  localparam int NENT = 16;
  localparam logic [47:0] TLIM = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  radio_phy_state_tracker_core #(.BUSY_ENTRIES(NENT)) dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Tracker state mirror
  logic [47:0] m_tx_end, m_tx_begin, m_rx_end, m_rx_begin, m_sw_end, m_sleep_begin;
  logic        m_asleep, m_off;
  logic [47:0] m_bend [NENT];
  logic        m_bend_ok [NENT];
  logic [47:0] m_bbeg [NENT];
  logic        m_bbeg_ok [NENT];
  logic [7:0]  m_band [NENT];

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   n_events = 0;
  int   n_rsp = 0;
  int   n_faults = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   span_cnt;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TLIM : s[47:0];
  endfunction

  function automatic logic [47:0] sub_floor(logic [47:0] a, logic [47:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [47:0] later(logic [47:0] a, logic [47:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [2:0] resolve_state(logic [3:0] e, logic [47:0] t);
    if (m_off) return ST_OFF;
    if (m_asleep) return ST_SLEEP;
    if (m_tx_end > t) return ST_TX;
    if (m_rx_end > t) return ST_RX;
    if (m_sw_end > t) return ST_SWITCH;
    if (m_bend_ok[e] && m_bend[e] > t) return ST_BUSY;
    return ST_IDLE;
  endfunction

  task automatic push_span(logic [2:0] s, logic [47:0] start, logic [47:0] len);
    rsp_t r;
    if (span_cnt >= 3) return;
    r = '0;
    r.kind = KIND_SPAN;
    r.span_state = s;
    r.span_start = start;
    r.span_length = len;
    pending_rsp.insert(pending_rsp.size(), r);
    span_cnt++;
  endtask

  task automatic close_busy_span(logic [3:0] e, logic [47:0] t);
    logic [47:0] s;
    s = later(m_rx_end, m_tx_end);
    if (m_bbeg_ok[e]) s = later(s, m_bbeg[e]);
    s = later(s, m_sw_end);
    push_span(ST_BUSY, s, sub_floor(t, s));
  endtask

  task automatic close_idle_span(logic [3:0] e, logic [47:0] t);
    logic [47:0] ec, is, bs;
    ec = m_bend_ok[e] ? m_bend[e] : '0;
    is = later(later(ec, m_rx_end), later(m_tx_end, m_sw_end));
    if (ec > m_rx_end && ec > m_sw_end && ec > m_tx_end) begin
      bs = later(m_tx_end, m_rx_end);
      if (m_bbeg_ok[e]) bs = later(bs, m_bbeg[e]);
      bs = later(bs, m_sw_end);
      push_span(ST_BUSY, bs, sub_floor(is, bs));
    end
    push_span(ST_IDLE, is, sub_floor(t, is));
  endtask

  task automatic stretch_entry(logic [3:0] e, logic [47:0] endv, logic [7:0] b);
    m_bend[e] = m_bend_ok[e] ? later(m_bend[e], endv) : endv;
    m_bend_ok[e] = 1'b1;
    m_band[e] = b;
  endtask

  task automatic sweep_bands(logic [7:0] b, logic [47:0] t, logic [47:0] endv);
    for (int i = 0; i < NENT; i++) begin
      if (m_bbeg_ok[i] && m_band[i] != b && t < m_bbeg[i]) m_bbeg[i] = t;
      if (m_bend_ok[i] && m_band[i] != b) m_bend[i] = later(m_bend[i], endv);
    end
  endtask

  task automatic clear_tracker();
    {m_tx_end, m_tx_begin, m_rx_end, m_rx_begin, m_sw_end, m_sleep_begin} = '0;
    m_asleep = 1'b0;
    m_off = 1'b0;
    for (int i = 0; i < NENT; i++) begin
      m_bend[i] = '0; m_bend_ok[i] = 1'b0; m_bbeg[i] = '0; m_bbeg_ok[i] = 1'b0;
      m_band[i] = '0;
    end
  endtask

  // Predict the transactions one event produces and queue them.
  task automatic predict_event(req_t q);
    logic [3:0] e;
    logic [47:0] t, d, endv, du, is, mag;
    logic [2:0] st;
    logic flt;
    rsp_t r;
    e = q.entry_index; t = q.now; d = q.duration;
    endv = sat_add(t, d);
    st = resolve_state(e, t);
    flt = 1'b0;
    span_cnt = 0;
    case (q.operation)
      OP_QUERY: ;
      OP_TX, OP_SWITCH: begin
        if (st == ST_RX) begin
          push_span(ST_RX, m_rx_begin, sub_floor(t, m_rx_begin));
          m_rx_end = t;
        end else if (st == ST_BUSY) close_busy_span(e, t);
        else if (st == ST_IDLE) close_idle_span(e, t);
        else flt = 1'b1;
        if (!flt) begin
          if (q.operation == OP_TX) begin
            push_span(ST_TX, t, d);
            m_tx_end = endv; m_tx_begin = t;
            sweep_bands(q.band_id, t, endv);
          end else begin
            for (int i = 0; i < NENT; i++)
              if (m_bend_ok[i] && t < m_bend[i]) m_bend[i] = t;
            push_span(ST_SWITCH, t, d);
            m_sw_end = endv;
          end
        end
      end
      OP_RX, OP_SLEEP: begin
        if (st == ST_IDLE) close_idle_span(e, t);
        else if (st == ST_BUSY) close_busy_span(e, t);
        else flt = 1'b1;
        if (!flt) begin
          if (q.operation == OP_RX) begin
            m_rx_begin = t; m_rx_end = endv;
            sweep_bands(q.band_id, t, endv);
          end else begin
            m_asleep = 1'b1; m_sleep_begin = t;
          end
        end
      end
      OP_RX_END: begin
        push_span(ST_RX, m_rx_begin, sub_floor(t, m_rx_begin));
        m_rx_end = t;
      end
      OP_BUSY: begin
        stretch_entry(e, endv, q.band_id);
        st = resolve_state(e, t);
        if (st != ST_RX) begin
          if (st == ST_IDLE && q.is_primary) close_idle_span(e, t);
          if (st != ST_BUSY) begin
            m_bbeg[e] = t; m_bbeg_ok[e] = 1'b1; m_band[e] = q.band_id;
          end
          if (q.is_primary) push_span(ST_BUSY, t, d);
        end
      end
      OP_WAKE: begin
        if (st != ST_SLEEP) flt = 1'b1;
        else begin
          m_asleep = 1'b0;
          if (q.is_primary) push_span(ST_SLEEP, m_sleep_begin, sub_floor(t, m_sleep_begin));
          stretch_entry(e, endv, q.band_id);
        end
      end
      OP_OFF: begin
        if (st == ST_RX) begin
          push_span(ST_RX, m_rx_begin, sub_floor(t, m_rx_begin));
          m_rx_end = t;
        end else if (st == ST_TX) begin
          push_span(ST_TX, m_tx_begin, sub_floor(t, m_tx_begin));
          m_tx_end = t;
        end else if (st == ST_IDLE) close_idle_span(e, t);
        else if (st == ST_BUSY) close_busy_span(e, t);
        else flt = 1'b1;
        if (!flt) m_off = 1'b1;
      end
      OP_ON: begin
        if (st != ST_OFF) flt = 1'b1;
        else begin
          m_off = 1'b0;
          stretch_entry(e, endv, q.band_id);
        end
      end
      default: flt = 1'b1;
    endcase
    st = resolve_state(e, t);
    case (st)
      ST_RX: du = sub_floor(m_rx_end, t);
      ST_TX: du = sub_floor(m_tx_end, t);
      ST_SWITCH: du = sub_floor(m_sw_end, t);
      ST_BUSY: du = m_bend_ok[e] ? sub_floor(m_bend[e], t) : '0;
      default: du = '0;
    endcase
    is = later(later(m_tx_end, m_rx_end), m_sw_end);
    if (m_bend_ok[e]) is = later(is, m_bend[e]);
    if (t >= is) begin
      mag = t - is;
      if (mag > 48'h7FFF_FFFF_FFFF) mag = 48'h7FFF_FFFF_FFFF;
    end else begin
      mag = is - t;
      if (mag > 48'h8000_0000_0000) mag = 48'h8000_0000_0000;
      mag = -mag;
    end
    r = '0;
    r.kind = KIND_STATUS;
    r.current_state = st;
    r.delay_until_idle = du;
    r.delay_since_idle = mag;
    r.fault = flt;
    r.last = 1'b1;
    pending_rsp.insert(pending_rsp.size(), r);
    if (flt) n_faults++;
  endtask

  // Send one event; predict it at its accepting edge. Valid drops only while idling.
  task automatic send_event(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_event(q);
    n_events++;
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    rsp_t x;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction %h", $time, rsp);
      end else begin
        x = pending_rsp.pop_front();
        if (rsp !== x) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, x, rsp);
        end
      end
    end
  end

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  // Directed rows; an expected status is typed in where exp_on is set.
  typedef struct {
    req_t q;
    bit   exp_on;
    logic [2:0] exp_state;
    logic exp_fault;
  } row_t;

  function automatic req_t ev(logic [3:0] op, logic [47:0] t, logic [47:0] d,
                              logic [3:0] e, logic [7:0] b, logic p);
    req_t q;
    q.operation = op; q.now = t; q.duration = d; q.entry_index = e;
    q.band_id = b; q.is_primary = p;
    return q;
  endfunction

  logic [47:0] clock_ns = '0;

  function automatic req_t rand_event(bit noisy);
    logic [3:0] op;
    logic [47:0] d;
    if (noisy) op = 4'($urandom_range(15));
    else begin
      case ($urandom_range(9))
        0, 1: op = OP_TX;
        2, 3: op = OP_RX;
        4, 5: op = OP_BUSY;
        6: op = OP_RX_END;
        7: op = OP_SWITCH;
        8: op = ($urandom_range(1)) ? OP_SLEEP : OP_WAKE;
        default: op = ($urandom_range(1)) ? OP_OFF : ($urandom_range(1) ? OP_ON : OP_QUERY);
      endcase
    end
    d = {$urandom_range(3) == 0 ? 16'($urandom) : 16'h0, 32'($urandom_range(400))};
    if ($urandom_range(19) == 0) d = 48'({$urandom, $urandom});
    if ($urandom_range(9) == 0)
      clock_ns = 48'({$urandom, $urandom});
    else
      clock_ns = sat_add(clock_ns, 48'($urandom_range(300)));
    return ev(op, clock_ns, d, 4'($urandom),
              8'($urandom_range(3) == 0 ? $urandom : $urandom_range(2)), 1'($urandom));
  endfunction

  initial begin
    #5_000_000;
    $display("radio_phy_state_tracker_core verification failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    rsp_t got;
    int ph;
    clear_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{ev(OP_QUERY, 48'd0, 48'd0, 4'd0, 8'd0, 1'b0), 1'b1, ST_IDLE, 1'b0},
      '{ev(OP_WAKE, 48'd10, 48'd5, 4'd1, 8'd1, 1'b1), 1'b1, ST_IDLE, 1'b1},
      '{ev(OP_ON, 48'd10, 48'd5, 4'd1, 8'd1, 1'b1), 1'b1, ST_IDLE, 1'b1},
      '{ev(4'd10, 48'd11, 48'd0, 4'd0, 8'd0, 1'b0), 1'b1, ST_IDLE, 1'b1},
      '{ev(4'd15, 48'd11, 48'd0, 4'd15, 8'hFF, 1'b1), 1'b1, ST_IDLE, 1'b1},
      '{ev(OP_BUSY, 48'd20, 48'd50, 4'd3, 8'd1, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_BUSY, 48'd25, 48'd10, 4'd4, 8'd2, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_TX, 48'd30, 48'd20, 4'd3, 8'd1, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_RX, 48'd40, 48'd10, 4'd3, 8'd1, 1'b1), 1'b1, ST_TX, 1'b1},
      '{ev(OP_RX, 48'd60, 48'd100, 4'd3, 8'd2, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_TX, 48'd70, 48'd5, 4'd3, 8'd2, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_RX, 48'd80, 48'd100, 4'd15, 8'hFF, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_RX_END, 48'd90, 48'd0, 4'd15, 8'd0, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_SWITCH, 48'd100, 48'd30, 4'd3, 8'd0, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_SLEEP, 48'd110, 48'd0, 4'd3, 8'd0, 1'b1), 1'b1, ST_SWITCH, 1'b1},
      '{ev(OP_SLEEP, 48'd200, 48'd0, 4'd3, 8'd0, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_OFF, 48'd210, 48'd0, 4'd3, 8'd0, 1'b1), 1'b1, ST_SLEEP, 1'b1},
      '{ev(OP_WAKE, 48'd300, 48'd40, 4'd0, 8'd7, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_OFF, 48'd310, 48'd0, 4'd0, 8'd7, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_TX, 48'd320, 48'd5, 4'd0, 8'd7, 1'b1), 1'b1, ST_OFF, 1'b1},
      '{ev(OP_ON, 48'd330, TLIM, 4'd0, 8'd7, 1'b1), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_TX, TLIM - 48'd2, TLIM, 4'd5, 8'hFF, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_QUERY, 48'd1, 48'd0, 4'd5, 8'd0, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_OFF, TLIM, 48'd0, 4'd0, 8'd0, 1'b0), 1'b0, ST_IDLE, 1'b0},
      '{ev(OP_QUERY, TLIM, TLIM, 4'd15, 8'hFF, 1'b1), 1'b1, ST_OFF, 1'b0}
    };

    foreach (rows[k]) begin
      rw = rows[k];
      send_event(rw.q);
      if (rw.exp_on) begin
        got = pending_rsp[pending_rsp.size() - 1];
        if (got.current_state !== rw.exp_state || got.fault !== rw.exp_fault) begin
          errors++;
          $display("%0t: row %0d expected state %0d fault %0b actual state %0d fault %0b",
                   $time, k, rw.exp_state, rw.exp_fault, got.current_state, got.fault);
        end
      end
    end

    // Random part in four phases of send idling and rsp stalls; power on first so sequences go deep.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      clock_ns = sat_add(clock_ns, 48'd1);
      send_event(ev(OP_ON, clock_ns, 48'd0, 4'd0, 8'd0, 1'b0));
      repeat (63) send_event(rand_event($urandom_range(9) == 0));
    end
    req_valid <= 1'b0;

    stall_pct = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d events, %0d transactions checked, %0d illegal events seen.",
             n_events, n_rsp, n_faults);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("radio_phy_state_tracker_core verification clean");
    else
      $display("radio_phy_state_tracker_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
